>>> hw/rtl/pppoe_passthrough_mac_learner_unit_assert.svh
// Assertion macros used by the learner's checker file
`ifndef PPPOE_PASSTHROUGH_MAC_LEARNER_UNIT_ASSERT_SVH
`define PPPOE_PASSTHROUGH_MAC_LEARNER_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define PMLRN_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pmlrn assertion failed");

// next-cycle implication, disabled in reset
`define PMLRN_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pmlrn assertion failed");

`endif

>>> hw/rtl/pmlrn_pkg.sv
// Types and constants of the PPPoE passthrough MAC learner
package pmlrn_pkg;

    localparam int MAC_W   = 48;
    localparam int ETYPE_W = 16;
    localparam int PORT_W  = 2;
    localparam int ACT_W   = 2;

    localparam logic [ETYPE_W-1:0] ETYPE_PPPOE_DISC = 16'h8863;
    localparam logic [ETYPE_W-1:0] ETYPE_PPPOE_SESS = 16'h8864;

    localparam logic [PORT_W-1:0] PORT_LAN = 2'd0;
    localparam logic [PORT_W-1:0] PORT_WAN = 2'd1;

    localparam logic [ACT_W-1:0] ACT_NONE   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_TO_WAN = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TO_LAN = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_CMP  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

endpackage

>>> hw/rtl/pmlrn_table.sv
// Address table: single-port write, registered read, shared 48-bit comparator
module pmlrn_table #(
    parameter int TABLE_ENTRIES = 16,
    parameter int IDX_W         = 4
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [IDX_W-1:0]           wr_addr,
    input  logic [pmlrn_pkg::MAC_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [IDX_W-1:0]           rd_addr,
    input  logic [pmlrn_pkg::MAC_W-1:0] key,
    output logic                       match
);

    logic [pmlrn_pkg::MAC_W-1:0] mem [TABLE_ENTRIES];
    logic [pmlrn_pkg::MAC_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign match = (rd_data_reg == key);

endmodule

>>> hw/rtl/pppoe_passthrough_mac_learner_unit.sv
// Top level of the PPPoE passthrough MAC learner
//
// Input channel s_*: one Ethernet header per word (ingress port, ethertype,
// source and destination MAC). Result channel m_*: one word per input word,
// carrying action, newly_learned and table_full. Both use valid/ready.
// cfg_we/cfg_wdata write the enable bit; write it only while the block is idle.
//
// A frame that is not handled (disabled, other ethertype, other port) goes
// from acceptance straight to ST_DONE, as does a handled one while the table
// is empty. Otherwise the table is searched one entry at a time (memory read
// in ST_READ, then compare on the shared comparator in ST_CMP), stopping at
// the first hit or after the last stored entry. s_ready rises again at the
// edge that loads the result; no new word is taken while one is in flight.
//
// The result sits in an output register; the next word is taken and searched
// while it waits, and only the next load waits for m_ready.
// Reset clears the entry count, the enable bit and all handshake state; the
// table contents are not cleared, as only entries below the count are read.
// Usable capacity is TABLE_ENTRIES-1 addresses; once full, new LAN sources are
// forwarded with table_full set and are not learned.
module pppoe_passthrough_mac_learner_unit #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic                          cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [pmlrn_pkg::PORT_W-1:0]  s_ingress_port,
    input  logic [pmlrn_pkg::ETYPE_W-1:0] s_ether_type,
    input  logic [pmlrn_pkg::MAC_W-1:0]   s_source_mac,
    input  logic [pmlrn_pkg::MAC_W-1:0]   s_dest_mac,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pmlrn_pkg::ACT_W-1:0]   m_action,
    output logic                          m_newly_learned,
    output logic                          m_table_full
);

    // count never exceeds TABLE_ENTRIES-1, so index width suffices for it
    localparam int IDX_W = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_CNT = IDX_W'(TABLE_ENTRIES - 1);

    pmlrn_pkg::state_t state_reg, state_next;

    logic                         enable_reg;
    logic [IDX_W-1:0]             count_reg, count_next;
    logic [IDX_W-1:0]             idx_reg, idx_next;
    logic                         handled_reg, handled_next;  // PPPoE on LAN or WAN, enabled
    logic                         lan_reg, lan_next;          // LAN side: learn path
    logic                         hit_reg, hit_next;
    logic [pmlrn_pkg::MAC_W-1:0]  key_reg, key_next;

    logic                         out_valid_reg, out_valid_next;
    logic [pmlrn_pkg::ACT_W-1:0]  action_reg, action_next;
    logic                         learned_reg, learned_next;
    logic                         full_reg, full_next;

    logic             accept;
    logic             in_handled;
    logic             load;
    logic             rd_en;
    logic             wr_en;
    logic             match;
    logic [IDX_W-1:0] idx_plus;

    assign s_ready = (state_reg == pmlrn_pkg::ST_IDLE);
    assign accept  = s_valid && s_ready;

    assign in_handled = enable_reg
        && ((s_ether_type == pmlrn_pkg::ETYPE_PPPOE_DISC)
            || (s_ether_type == pmlrn_pkg::ETYPE_PPPOE_SESS))
        && ((s_ingress_port == pmlrn_pkg::PORT_LAN)
            || (s_ingress_port == pmlrn_pkg::PORT_WAN));

    assign idx_plus = idx_reg + 1'b1;
    assign rd_en    = (state_reg == pmlrn_pkg::ST_READ);
    // output register free, or being emptied this cycle
    assign load     = (state_reg == pmlrn_pkg::ST_DONE) && (!out_valid_reg || m_ready);
    // learn a new LAN source while a free slot remains
    assign wr_en    = load && handled_reg && lan_reg && !hit_reg && (count_reg != LAST_CNT);

    pmlrn_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg),
        .wr_data (key_reg),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .key     (key_reg),
        .match   (match)
    );

    // sequencer
    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        handled_next = handled_reg;
        lan_next     = lan_reg;
        hit_next     = hit_reg;
        key_next     = key_reg;
        count_next   = count_reg;

        unique case (state_reg)
            pmlrn_pkg::ST_IDLE: begin
                if (accept) begin
                    handled_next = in_handled;
                    lan_next     = (s_ingress_port == pmlrn_pkg::PORT_LAN);
                    key_next     = (s_ingress_port == pmlrn_pkg::PORT_LAN) ?
                                   s_source_mac : s_dest_mac;
                    hit_next     = 1'b0;
                    idx_next     = '0;
                    if (in_handled && (count_reg != '0)) begin
                        state_next = pmlrn_pkg::ST_READ;
                    end else begin
                        state_next = pmlrn_pkg::ST_DONE;
                    end
                end
            end
            pmlrn_pkg::ST_READ: begin
                state_next = pmlrn_pkg::ST_CMP;
            end
            pmlrn_pkg::ST_CMP: begin
                if (match) begin
                    hit_next   = 1'b1;
                    state_next = pmlrn_pkg::ST_DONE;
                end else if (idx_plus == count_reg) begin
                    state_next = pmlrn_pkg::ST_DONE;
                end else begin
                    idx_next   = idx_plus;
                    state_next = pmlrn_pkg::ST_READ;
                end
            end
            pmlrn_pkg::ST_DONE: begin
                if (load) begin
                    state_next = pmlrn_pkg::ST_IDLE;
                end
                if (wr_en) begin
                    count_next = count_reg + 1'b1;
                end
            end
            default: begin
                state_next = pmlrn_pkg::ST_IDLE;
            end
        endcase
    end

    // result register
    always_comb begin
        out_valid_next = out_valid_reg;
        action_next    = action_reg;
        learned_next   = learned_reg;
        full_next      = full_reg;

        if (load) begin
            out_valid_next = 1'b1;
            learned_next   = wr_en;
            full_next      = handled_reg && lan_reg && !hit_reg && (count_reg == LAST_CNT);
            if (!handled_reg) begin
                action_next = pmlrn_pkg::ACT_NONE;
            end else if (lan_reg) begin
                action_next = pmlrn_pkg::ACT_TO_WAN;
            end else if (hit_reg) begin
                action_next = pmlrn_pkg::ACT_TO_LAN;
            end else begin
                action_next = pmlrn_pkg::ACT_NONE;
            end
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pmlrn_pkg::ST_IDLE;
            enable_reg    <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                enable_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        handled_reg <= handled_next;
        lan_reg     <= lan_next;
        hit_reg     <= hit_next;
        key_reg     <= key_next;
        action_reg  <= action_next;
        learned_reg <= learned_next;
        full_reg    <= full_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_action        = action_reg;
    assign m_newly_learned = learned_reg;
    assign m_table_full    = full_reg;

endmodule

>>> hw/rtl/pmlrn_checker.sv
// Port-level checker for the learner, bound to the top level
`include "pppoe_passthrough_mac_learner_unit_assert.svh"

module pmlrn_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          cfg_we,
    input logic                          cfg_wdata,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [pmlrn_pkg::PORT_W-1:0]  s_ingress_port,
    input logic [pmlrn_pkg::ETYPE_W-1:0] s_ether_type,
    input logic [pmlrn_pkg::MAC_W-1:0]   s_source_mac,
    input logic [pmlrn_pkg::MAC_W-1:0]   s_dest_mac,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [pmlrn_pkg::ACT_W-1:0]   m_action,
    input logic                          m_newly_learned,
    input logic                          m_table_full
);

    // learn and full are exclusive
    `PMLRN_ASSERT_IMPL(a_learn_full_excl, aclk, aresetn,
        m_valid, !(m_newly_learned && m_table_full))

    // learn or full only on a frame forwarded to the WAN side
    `PMLRN_ASSERT_IMPL(a_flags_wan_only, aclk, aresetn,
        m_valid && (m_newly_learned || m_table_full),
        m_action == pmlrn_pkg::ACT_TO_WAN)

    // after an accepted word, s_ready is low in the next cycle
    `PMLRN_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn,
        s_valid && s_ready, !s_ready)

    // a pending result is held until taken
    `PMLRN_ASSERT_NEXT(a_result_held, aclk, aresetn,
        m_valid && !m_ready, m_valid)

endmodule

bind pppoe_passthrough_mac_learner_unit pmlrn_checker u_pmlrn_checker (.*);
